### src/sspf_pkg.sv
// Package for the serial-to-servo pulse framer: frame geometry, channel
// counts, parser and sequencer state types, and the structs between blocks.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sspf_pkg;

    // Frame geometry
    localparam int CHANNEL_COUNT     = 9;
    localparam int PPM_CHANNEL_COUNT = 8;
    localparam int WIRED_OUTPUTS     = 9;
    localparam int PPM_LIMIT         = 8;

    localparam int PAYLOAD_BYTES = 2 * CHANNEL_COUNT;
    localparam int PPM_N = (PPM_CHANNEL_COUNT > PPM_LIMIT) ? PPM_LIMIT : PPM_CHANNEL_COUNT;

    // Counter and index widths
    localparam int CNT_W    = $clog2(PAYLOAD_BYTES + 1);
    localparam int ST_IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int SEG_W    = 5;

    // Byte codes
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] TRAILER_BYTE = 8'hEE;

    // Register reset values and map
    localparam logic [15:0] PRE_PULSE_RST = 16'd2949;
    localparam logic [15:0] SYNC_GAP_RST  = 16'(33915 - 2949);
    localparam int          ADDR_W        = 4;

    typedef enum logic [1:0] {
        REG_PPM_MODE  = 2'd0,
        REG_PRE_PULSE = 2'd1,
        REG_SYNC_GAP  = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_SEARCH1,
        PH_SEARCH2,
        PH_PAYLOAD,
        PH_TRAILER
    } t_phase;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_bk_state;

    // One complete frame of channel values, high byte first on the wire
    typedef logic [CHANNEL_COUNT-1:0][15:0] t_frame;

    typedef struct packed {
        logic   push;
        t_frame frame;
    } t_frame_req;

    typedef struct packed {
        logic  full;
        logic  empty;
    } t_q_status;

    typedef struct packed {
        logic        ppm_mode;
        logic [15:0] pre_pulse;
        logic [15:0] sync_gap;
    } t_cfg;

endpackage

`default_nettype wire

### src/sspf_front.sv
// Front end of the framer: accepts serial bytes, tracks sync/payload/trailer
// and keeps the payload store. Hands finished frames to the frame queue.
// Depends on sspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sspf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire sspf_pkg::t_q_status i_q_status,
    output sspf_pkg::t_frame_req   o_req
);
    import sspf_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_store [PAYLOAD_BYTES];
    logic             accept;
    logic [CNT_W-1:0] count_inc;

    // Only the trailer byte may need queue space
    assign o_ready   = !((r_phase == PH_TRAILER) && i_q_status.full);
    assign accept    = i_valid && o_ready;
    assign count_inc = r_count + CNT_W'(1);

    // Parser next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (accept) begin
            unique case (r_phase)
                PH_SEARCH1: begin
                    if (i_rx_byte == SYNC_BYTE) n_phase = PH_SEARCH2;
                end
                PH_SEARCH2: begin
                    if (i_rx_byte == SYNC_BYTE) begin
                        n_phase = PH_PAYLOAD;
                        n_count = '0;
                    end else begin
                        n_phase = PH_SEARCH1;
                    end
                end
                PH_PAYLOAD: begin
                    n_count = count_inc;
                    if (count_inc >= CNT_W'(PAYLOAD_BYTES)) n_phase = PH_TRAILER;
                end
                PH_TRAILER: begin
                    n_phase = PH_SEARCH1;
                end
                default: n_phase = PH_SEARCH1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH1;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Payload store, no reset: always filled before the trailer
    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_PAYLOAD)) begin
            r_store[r_count[ST_IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // Frame request on a good trailer
    always_comb begin
        o_req.push = accept && (r_phase == PH_TRAILER) && (i_rx_byte == TRAILER_BYTE);
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            o_req.frame[i] = {r_store[2*i], r_store[2*i+1]};
        end
    end

endmodule

`default_nettype wire

### src/sspf_queue.sv
// Two-entry frame queue between the parser and the segment sequencer.
// Depends on sspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sspf_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sspf_pkg::t_frame_req i_req,
    input  wire logic                i_pop,
    output sspf_pkg::t_frame         o_frame,
    output sspf_pkg::t_q_status      o_status
);
    import sspf_pkg::*;

    t_frame     r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign do_push = i_req.push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_frame = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) r_wptr <= !r_wptr;
            if (do_pop)  r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // Frame storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_req.frame;
    end

endmodule

`default_nettype wire

### src/sspf_back.sv
// Back end of the framer: takes one frame from the queue and steps its PWM
// or PPM segments into an output register, one per cycle unless stalled.
// Depends on sspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sspf_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sspf_pkg::t_cfg       i_cfg,
    input  wire sspf_pkg::t_frame     i_frame,
    input  wire sspf_pkg::t_q_status  i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_ppm_level,
    output logic                      o_channel_active,
    output logic [3:0]                o_channel_index,
    output logic [15:0]               o_duration_ticks,
    output logic                      o_last_segment
);
    import sspf_pkg::*;

    t_bk_state        r_state, n_state;
    logic [SEG_W-1:0] r_seg, n_seg;
    t_frame           r_frame;
    logic             r_valid, n_valid;
    logic             r_lvl, r_act, r_last;
    logic [3:0]       r_idx;
    logic [15:0]      r_dur;

    logic             slot_free, emit;
    logic [3:0]       ch;
    logic [15:0]      ch_val;
    logic             s_lvl, s_act, s_last;
    logic [3:0]       s_idx;
    logic [15:0]      s_dur;

    assign slot_free = !r_valid || i_ready;

    // Channel value, zero beyond the payload
    always_comb begin
        ch = i_cfg.ppm_mode ? r_seg[4:1] : r_seg[3:0];
        if ({1'b0, ch} < 5'(CHANNEL_COUNT)) ch_val = r_frame[ch[CH_IDX_W-1:0]];
        else                                 ch_val = 16'd0;
    end

    // Segment fields for the current step
    always_comb begin
        s_lvl  = 1'b0;
        s_act  = 1'b0;
        s_idx  = ch;
        s_dur  = ch_val;
        s_last = 1'b0;
        if (i_cfg.ppm_mode) begin
            priority if (r_seg == SEG_W'(2*PPM_N)) begin
                s_lvl = 1'b1;
                s_idx = 4'd0;
                s_dur = i_cfg.pre_pulse;
            end else if (r_seg == SEG_W'(2*PPM_N+1)) begin
                s_idx  = 4'd0;
                s_dur  = i_cfg.sync_gap;
                s_last = 1'b1;
            end else begin
                s_lvl = !r_seg[0];
                s_act = ({1'b0, ch} < 5'(WIRED_OUTPUTS - 1));
                s_dur = r_seg[0] ? (ch_val - i_cfg.pre_pulse) : i_cfg.pre_pulse;
            end
        end else begin
            s_act  = ({1'b0, ch} < 5'(WIRED_OUTPUTS));
            s_last = (r_seg == SEG_W'(CHANNEL_COUNT - 1));
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_valid = r_valid && !i_ready;
        o_pop   = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_seg   = '0;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_valid = 1'b1;
                    n_seg   = r_seg + SEG_W'(1);
                    if (s_last) n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_seg   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_valid <= n_valid;
        end
    end

    // Working frame and output register
    always_ff @(posedge i_clk) begin
        if (o_pop) r_frame <= i_frame;
        if (emit) begin
            r_lvl  <= s_lvl;
            r_act  <= s_act;
            r_idx  <= s_idx;
            r_dur  <= s_dur;
            r_last <= s_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_ppm_level      = r_lvl;
    assign o_channel_active = r_act;
    assign o_channel_index  = r_idx;
    assign o_duration_ticks = r_dur;
    assign o_last_segment   = r_last;

endmodule

`default_nettype wire

### src/serial_to_servo_pulse_framer.sv
// Serial-to-servo pulse framer, top level: register port, parser front end,
// frame queue and segment sequencer. Depends on sspf_pkg and its submodules.
//
// Bytes are taken one per cycle while o_ready is high. A frame is 0xFF 0xFF,
// two bytes per channel (high byte first) and the trailer 0xEE; a good
// trailer queues the frame and the sequencer loads it and then emits its
// segments one per cycle while the output is not stalled: CHANNEL_COUNT
// segments in PWM mode, 2*min(PPM_CHANNEL_COUNT,8)+2 in PPM mode (18 with
// the defaults). The first segment passes the queue entry, the sequencer's
// load step and the segment output register before it is presented.
// The two-entry frame queue sets how far the parser can run ahead: the
// trailer byte is held off while two frames are waiting. Registers at byte
// addresses 0 (ppm_mode), 4 (pre_pulse_ticks) and 8 (sync_gap_ticks); change
// them only while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module serial_to_servo_pulse_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Byte input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    // Segment output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_ppm_level,
    output logic             o_channel_active,
    output logic [3:0]       o_channel_index,
    output logic [15:0]      o_duration_ticks,
    output logic             o_last_segment,
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [sspf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sspf_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   reg_sel;
    t_frame_req req;
    t_q_status  q_status;
    t_frame     q_frame;
    logic       pop;
    logic       cfg_wr;

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppm_mode  <= 1'b0;
            r_cfg.pre_pulse <= PRE_PULSE_RST;
            r_cfg.sync_gap  <= SYNC_GAP_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_PPM_MODE:  r_cfg.ppm_mode  <= pwdata[0];
                REG_PRE_PULSE: r_cfg.pre_pulse <= pwdata[15:0];
                REG_SYNC_GAP:  r_cfg.sync_gap  <= pwdata[15:0];
                REG_NONE:      ;
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_PPM_MODE:  prdata = {31'd0, r_cfg.ppm_mode};
            REG_PRE_PULSE: prdata = {16'd0, r_cfg.pre_pulse};
            REG_SYNC_GAP:  prdata = {16'd0, r_cfg.sync_gap};
            default:       prdata = 32'd0;
        endcase
    end

    sspf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (q_status),
        .o_req      (req)
    );

    sspf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_pop    (pop),
        .o_frame  (q_frame),
        .o_status (q_status)
    );

    sspf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_frame          (q_frame),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_ppm_level      (o_ppm_level),
        .o_channel_active (o_channel_active),
        .o_channel_index  (o_channel_index),
        .o_duration_ticks (o_duration_ticks),
        .o_last_segment   (o_last_segment)
    );

    // Checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !req.push)
        else $error("frame pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("frame popped from empty queue");

    a_pwm_level_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_cfg.ppm_mode) |-> !o_ppm_level)
        else $error("PPM level high in PWM mode");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_segment && i_ready) |=> (!o_valid || !o_last_segment))
        else $error("last segment repeated");

endmodule

`default_nettype wire
